// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define CRHP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define CRHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/crhp_pkg.sv -----
// Shared types, codes and constants for the Content-Range header parser.
// Depends on nothing; used by the step logic, the top level and the checker.
`default_nettype none

package crhp_pkg;

  // Default width of each parsed number.
  localparam int NUMBER_BITS_DEF = 64;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_BYTES = 3'd1;
  localparam logic [2:0] ST_NEGATIVE  = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Length of the "bytes " prefix and the index of its final character.
  localparam logic [2:0] PREFIX_LEN  = 3'd6;
  localparam logic [2:0] PREFIX_LAST = 3'd5;

  typedef enum logic [2:0] {
    PH_PREFIX     = 3'd0,
    PH_FIRST      = 3'd1,
    PH_START      = 3'd2,
    PH_END        = 3'd3,
    PH_TOTAL      = 3'd4,
    PH_STAR_WAIT  = 3'd5,
    PH_STAR_TOTAL = 3'd6,
    PH_DONE       = 3'd7
  } phase_t;

  // One input request: a header byte and its end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [2:0]  status;
    logic        total_valid;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [63:0] total_length;
  } out_item_t;

  // Parser control state carried from byte to byte.
  typedef struct packed {
    phase_t     phase;
    logic [2:0] prefix_count;
    logic       digits_seen;
    logic       digits_stopped;
    logic       field_overflow;
    logic [2:0] latched_error;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    phase:          PH_PREFIX,
    prefix_count:   3'd0,
    digits_seen:    1'b0,
    digits_stopped: 1'b0,
    field_overflow: 1'b0,
    latched_error:  ST_OK
  };

  // Expected character at each position of the "bytes " prefix.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h62;  // b
      3'd1:    ch = 8'h79;  // y
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h73;  // s
      3'd5:    ch = 8'h20;  // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/crhp_step.sv -----
// Combinational next-state and result logic for one header byte.
// Depends on crhp_pkg.
`default_nettype none

module crhp_step #(
  parameter int NUMBER_BITS = crhp_pkg::NUMBER_BITS_DEF
) (
  input  crhp_pkg::in_item_t      item,
  input  crhp_pkg::ctl_t          ctl,
  input  logic [NUMBER_BITS-1:0]  acc,
  input  logic [NUMBER_BITS-1:0]  start_val,
  input  logic [NUMBER_BITS-1:0]  end_val,
  output crhp_pkg::ctl_t          ctl_nxt,
  output logic [NUMBER_BITS-1:0]  acc_nxt,
  output logic [NUMBER_BITS-1:0]  start_nxt,
  output logic [NUMBER_BITS-1:0]  end_nxt,
  output crhp_pkg::out_item_t     result
);

  localparam int PW = NUMBER_BITS + 4;

  logic [7:0]             c;
  logic [7:0]             diff;
  logic                   digit_hit;
  logic [3:0]             dval;
  logic [PW-1:0]          prod;
  logic                   dig_ovf;
  logic                   field_bad;
  logic                   td_seen;
  logic                   td_stop;
  logic                   td_ovf;
  logic [NUMBER_BITS-1:0] td_acc;
  crhp_pkg::ctl_t         a_ctl;
  logic [NUMBER_BITS-1:0] a_acc;
  logic [NUMBER_BITS-1:0] a_start;
  logic [NUMBER_BITS-1:0] a_end;

  // Decimal digit decode and multiply-by-ten accumulate with carry-out check.
  assign c         = item.data_byte;
  assign diff      = c - crhp_pkg::CH_ZERO;
  assign dval      = diff[3:0];
  assign digit_hit = (c >= crhp_pkg::CH_ZERO) && (c <= crhp_pkg::CH_NINE);
  assign prod      = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(PW-4){1'b0}}, dval};
  assign dig_ovf   = |prod[PW-1:NUMBER_BITS];

  assign field_bad = !ctl.digits_seen || ctl.field_overflow;

  // Effect of offering this byte to the current numeric field.
  always_comb begin
    td_seen = ctl.digits_seen;
    td_stop = ctl.digits_stopped;
    td_ovf  = ctl.field_overflow;
    td_acc  = acc;
    if (!ctl.digits_stopped) begin
      if (!digit_hit) begin
        td_stop = 1'b1;
      end else begin
        if (!ctl.field_overflow) begin
          if (dig_ovf) begin
            td_ovf = 1'b1;
          end else begin
            td_acc = prod[NUMBER_BITS-1:0];
          end
        end
        td_seen = 1'b1;
      end
    end
  end

  // Phase update for this byte.
  always_comb begin
    a_ctl   = ctl;
    a_acc   = acc;
    a_start = start_val;
    a_end   = end_val;
    case (ctl.phase)
      crhp_pkg::PH_PREFIX: begin
        if (ctl.prefix_count < crhp_pkg::PREFIX_LEN &&
            c == crhp_pkg::prefix_char(ctl.prefix_count)) begin
          a_ctl.prefix_count = ctl.prefix_count + 3'd1;
          if (ctl.prefix_count == crhp_pkg::PREFIX_LAST) begin
            a_ctl.phase = crhp_pkg::PH_FIRST;
          end
        end else begin
          a_ctl.latched_error = crhp_pkg::ST_NOT_BYTES;
          a_ctl.phase         = crhp_pkg::PH_DONE;
        end
      end
      crhp_pkg::PH_FIRST: begin
        if (c == crhp_pkg::CH_STAR) begin
          a_ctl.phase = crhp_pkg::PH_STAR_WAIT;
        end else if (c == crhp_pkg::CH_DASH) begin
          a_ctl.latched_error = crhp_pkg::ST_NEGATIVE;
          a_ctl.phase         = crhp_pkg::PH_DONE;
        end else begin
          a_ctl.phase          = crhp_pkg::PH_START;
          a_ctl.digits_seen    = td_seen;
          a_ctl.digits_stopped = td_stop;
          a_ctl.field_overflow = td_ovf;
          a_acc                = td_acc;
        end
      end
      crhp_pkg::PH_START: begin
        if (c == crhp_pkg::CH_DASH) begin
          if (field_bad) begin
            a_ctl.latched_error = crhp_pkg::ST_OVERFLOW;
            a_ctl.phase         = crhp_pkg::PH_DONE;
          end else begin
            a_start              = acc;
            a_acc                = '0;
            a_ctl.digits_seen    = 1'b0;
            a_ctl.digits_stopped = 1'b0;
            a_ctl.field_overflow = 1'b0;
            a_ctl.phase          = crhp_pkg::PH_END;
          end
        end else begin
          a_ctl.digits_seen    = td_seen;
          a_ctl.digits_stopped = td_stop;
          a_ctl.field_overflow = td_ovf;
          a_acc                = td_acc;
        end
      end
      crhp_pkg::PH_END: begin
        if (c == crhp_pkg::CH_SLASH) begin
          if (field_bad) begin
            a_ctl.latched_error = crhp_pkg::ST_OVERFLOW;
            a_ctl.phase         = crhp_pkg::PH_DONE;
          end else if (acc < start_val) begin
            a_ctl.latched_error = crhp_pkg::ST_INVALID;
            a_ctl.phase         = crhp_pkg::PH_DONE;
          end else begin
            a_end                = acc;
            a_acc                = '0;
            a_ctl.digits_seen    = 1'b0;
            a_ctl.digits_stopped = 1'b0;
            a_ctl.field_overflow = 1'b0;
            a_ctl.phase          = crhp_pkg::PH_TOTAL;
          end
        end else begin
          a_ctl.digits_seen    = td_seen;
          a_ctl.digits_stopped = td_stop;
          a_ctl.field_overflow = td_ovf;
          a_acc                = td_acc;
        end
      end
      crhp_pkg::PH_TOTAL: begin
        // A star right after the slash ends parsing without an error.
        if (c == crhp_pkg::CH_STAR && !ctl.digits_seen && !ctl.digits_stopped) begin
          a_ctl.phase = crhp_pkg::PH_DONE;
        end else begin
          a_ctl.digits_seen    = td_seen;
          a_ctl.digits_stopped = td_stop;
          a_ctl.field_overflow = td_ovf;
          a_acc                = td_acc;
        end
      end
      crhp_pkg::PH_STAR_WAIT: begin
        if (c == crhp_pkg::CH_SLASH) begin
          a_acc                = '0;
          a_ctl.digits_seen    = 1'b0;
          a_ctl.digits_stopped = 1'b0;
          a_ctl.field_overflow = 1'b0;
          a_ctl.phase          = crhp_pkg::PH_STAR_TOTAL;
        end
      end
      crhp_pkg::PH_STAR_TOTAL: begin
        a_ctl.digits_seen    = td_seen;
        a_ctl.digits_stopped = td_stop;
        a_ctl.field_overflow = td_ovf;
        a_acc                = td_acc;
      end
      default: begin
      end
    endcase
  end

  // Result built from the state after this byte; used only on the last byte.
  always_comb begin
    result = '0;
    case (a_ctl.phase)
      crhp_pkg::PH_PREFIX: begin
        result.status = crhp_pkg::ST_NOT_BYTES;
      end
      crhp_pkg::PH_FIRST, crhp_pkg::PH_START, crhp_pkg::PH_END: begin
        result.status = crhp_pkg::ST_INVALID;
      end
      crhp_pkg::PH_TOTAL: begin
        if (!a_ctl.digits_seen || a_ctl.field_overflow) begin
          result.status = crhp_pkg::ST_OVERFLOW;
        end else begin
          result.range_start  = 64'(a_start);
          result.range_end    = 64'(a_end);
          result.total_length = 64'(a_acc);
          result.total_valid  = 1'b1;
        end
      end
      crhp_pkg::PH_STAR_WAIT: begin
      end
      crhp_pkg::PH_STAR_TOTAL: begin
        if (a_ctl.digits_seen && !a_ctl.digits_stopped && !a_ctl.field_overflow) begin
          result.total_length = 64'(a_acc);
          result.total_valid  = 1'b1;
        end
      end
      default: begin
        if (a_ctl.latched_error != crhp_pkg::ST_OK) begin
          result.status = a_ctl.latched_error;
        end else begin
          result.range_start = 64'(a_start);
          result.range_end   = 64'(a_end);
        end
      end
    endcase
  end

  // The last byte of a header returns the parser to its reset state.
  always_comb begin
    if (item.last) begin
      ctl_nxt   = crhp_pkg::CTL_RESET;
      acc_nxt   = '0;
      start_nxt = '0;
      end_nxt   = '0;
    end else begin
      ctl_nxt   = a_ctl;
      acc_nxt   = a_acc;
      start_nxt = a_start;
      end_nxt   = a_end;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/content_range_header_parser.sv -----
// Content-Range header parser: takes one header byte per cycle while in_stall
// is low, and returns one result request on the byte marked last. The
// byte-to-byte path is the per-byte step logic (one multiply-by-ten accumulate
// and compare). An accepted byte is held in the input register; the result of
// a last byte is loaded into the result register, which drives out_valid.
// Bytes that are not last keep flowing while a result waits on out_stall; a
// last byte waits in the input register, with in_stall high, until the result
// register is free.
// Depends on crhp_pkg and crhp_step.
`default_nettype none

module content_range_header_parser #(
  parameter int NUMBER_BITS = crhp_pkg::NUMBER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crhp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crhp_pkg::out_item_t  out_data
);

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  crhp_pkg::in_item_t     s1_item_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  crhp_pkg::out_item_t    out_item_r;
  crhp_pkg::ctl_t         ctl_r;
  crhp_pkg::ctl_t         ctl_nxt;
  logic [NUMBER_BITS-1:0] acc_r;
  logic [NUMBER_BITS-1:0] acc_nxt;
  logic [NUMBER_BITS-1:0] start_r;
  logic [NUMBER_BITS-1:0] start_nxt;
  logic [NUMBER_BITS-1:0] end_r;
  logic [NUMBER_BITS-1:0] end_nxt;
  crhp_pkg::out_item_t    result;
  logic                   out_free;
  logic                   s1_go;
  logic                   in_accept;

  // Per-byte parse logic.
  crhp_step #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_step (
    .item      (s1_item_r),
    .ctl       (ctl_r),
    .acc       (acc_r),
    .start_val (start_r),
    .end_val   (end_r),
    .ctl_nxt   (ctl_nxt),
    .acc_nxt   (acc_nxt),
    .start_nxt (start_nxt),
    .end_nxt   (end_nxt),
    .result    (result)
  );

  // Flow control: a held byte advances unless it is last and the result slot is busy.
  assign out_free      = !out_valid_r || !out_stall;
  assign s1_go         = s1_valid_r && (!s1_item_r.last || out_free);
  assign in_stall      = s1_valid_r && !s1_go;
  assign in_accept     = in_valid && !in_stall;
  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_go);
  assign out_valid_nxt = (s1_go && s1_item_r.last) || (out_valid_r && out_stall);

  // Control state and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= crhp_pkg::CTL_RESET;
      acc_r       <= '0;
      start_r     <= '0;
      end_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        ctl_r   <= ctl_nxt;
        acc_r   <= acc_nxt;
        start_r <= start_nxt;
        end_r   <= end_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_go && s1_item_r.last) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/core/crhp_checker.sv -----
// Port-level checks for the Content-Range header parser, bound to the top level.
// Depends on crhp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module crhp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input crhp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input crhp_pkg::out_item_t out_data
);

  logic err_status;
  logic numbers_zero;
  logic in_held;
  logic out_held;
  logic err_out;
  logic bare_out;
  logic good_out;
  logic total_zero;
  logic range_ok;

  assign err_status   = out_data.status != crhp_pkg::ST_OK;
  assign numbers_zero = (out_data.range_start == 64'd0) && (out_data.range_end == 64'd0) &&
                        (out_data.total_length == 64'd0);
  assign in_held      = in_valid && in_stall;
  assign out_held     = out_valid && out_stall;
  assign err_out      = out_valid && err_status;
  assign bare_out     = out_valid && !out_data.total_valid;
  assign good_out     = out_valid && !err_status;
  assign total_zero   = out_data.total_length == 64'd0;
  assign range_ok     = out_data.range_end >= out_data.range_start;

  // A stalled result stays put.
  `CRHP_ASSERT(a_out_hold, clk, rst_n, out_held |=> out_valid && $stable(out_data), "result moved")

  // A stalled request stays put.
  `CRHP_ASSERT(a_in_hold, clk, rst_n, in_held |=> in_valid && $stable(in_data), "request moved")

  // An error result carries no numbers.
  `CRHP_ASSERT(a_err_zero, clk, rst_n, err_out |-> !out_data.total_valid && numbers_zero, "error with numbers")

  // Without a total, the total field is zero.
  `CRHP_ASSERT(a_no_total, clk, rst_n, bare_out |-> total_zero, "total without total_valid")

  // A good range never ends before it starts.
  `CRHP_ASSERT(a_range_order, clk, rst_n, good_out |-> range_ok, "range end below start")

endmodule

bind content_range_header_parser crhp_checker u_crhp_checker (.*);

`default_nettype wire

// ----- verif/content_range_header_parser_tb.sv -----
// Self-checking testbench for the Content-Range header parser; depends on
// crhp_pkg and the block. It drives header bytes on a valid/stall channel and
// checks each result request against its predictor or a fixed row's expectation.
module content_range_header_parser_tb;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 9;
  localparam int          RANDOM_BYTES  = 1230;
  localparam int          MAX_WAIT      = 18;
  localparam int          LONG_HOLD     = 600;
  localparam int          LONG_HOLD_AT  = 40;
  localparam int          DRAIN_CYCLES  = 10;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [63:0] NUM_MAX       =
    64'hFFFF_FFFF_FFFF_FFFF >> (64 - crhp_pkg::NUMBER_BITS_DEF);
  localparam logic [47:0] HEADER_PREFIX = "bytes ";

  typedef struct {
    string               text;
    bit                  fixed;
    crhp_pkg::out_item_t want;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  crhp_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  crhp_pkg::out_item_t out_data;

  // Parser state as the predictor sees it.
  crhp_pkg::phase_t parse_phase;
  logic [2:0]       prefix_pos;
  logic [63:0]      digit_acc;
  bit               got_digit;
  bit               digits_done;
  bit               acc_overflow;
  logic [63:0]      start_pos;
  logic [63:0]      end_pos;
  logic [2:0]       error_code;

  crhp_pkg::out_item_t pending_results[$];
  stim_row_t           stim_table[$];
  logic [7:0]          header_bytes[$];

  int error_count     = 0;
  int results_checked = 0;
  int bytes_sent      = 0;
  int headers_sent    = 0;
  int cycle_count     = 0;
  int in_mode         = 1;
  int out_mode        = 1;
  int status_count[0:4] = '{default: 0};

  content_range_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results still pending.",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void clear_number();
    digit_acc    = '0;
    got_digit    = 1'b0;
    digits_done  = 1'b0;
    acc_overflow = 1'b0;
  endfunction

  function automatic void reset_parser();
    parse_phase = crhp_pkg::PH_PREFIX;
    prefix_pos  = '0;
    clear_number();
    start_pos   = '0;
    end_pos     = '0;
    error_code  = crhp_pkg::ST_OK;
  endfunction

  // Leading decimal digits build the number; the first non-digit freezes it.
  function automatic void take_digit(input logic [7:0] c);
    logic [63:0] d;
    if (digits_done) return;
    if (c < crhp_pkg::CH_ZERO || c > crhp_pkg::CH_NINE) begin
      digits_done = 1'b1;
      return;
    end
    d = {56'd0, c - crhp_pkg::CH_ZERO};
    if (!acc_overflow) begin
      if (digit_acc > (NUM_MAX - d) / 64'd10) acc_overflow = 1'b1;
      else digit_acc = digit_acc * 64'd10 + d;
    end
    got_digit = 1'b1;
  endfunction

  function automatic void reject(input logic [2:0] code);
    error_code  = code;
    parse_phase = crhp_pkg::PH_DONE;
  endfunction

  function automatic bit number_bad();
    return !got_digit || acc_overflow;
  endfunction

  // Advances the parser by one byte; on the last byte it yields the result.
  task automatic parse_byte(input crhp_pkg::in_item_t item, output bit done,
                            output crhp_pkg::out_item_t res);
    logic [7:0] c;
    c    = item.data_byte;
    done = 1'b0;
    res  = '0;
    case (parse_phase)
      crhp_pkg::PH_PREFIX: begin
        if (prefix_pos < crhp_pkg::PREFIX_LEN &&
            c == HEADER_PREFIX[8 * (5 - int'(prefix_pos)) +: 8]) begin
          prefix_pos = prefix_pos + 3'd1;
          if (prefix_pos == crhp_pkg::PREFIX_LEN) parse_phase = crhp_pkg::PH_FIRST;
        end else begin
          reject(crhp_pkg::ST_NOT_BYTES);
        end
      end
      crhp_pkg::PH_FIRST: begin
        if (c == crhp_pkg::CH_STAR) begin
          parse_phase = crhp_pkg::PH_STAR_WAIT;
        end else if (c == crhp_pkg::CH_DASH) begin
          reject(crhp_pkg::ST_NEGATIVE);
        end else begin
          parse_phase = crhp_pkg::PH_START;
          take_digit(c);
        end
      end
      crhp_pkg::PH_START: begin
        if (c != crhp_pkg::CH_DASH) begin
          take_digit(c);
        end else if (number_bad()) begin
          reject(crhp_pkg::ST_OVERFLOW);
        end else begin
          start_pos = digit_acc;
          clear_number();
          parse_phase = crhp_pkg::PH_END;
        end
      end
      crhp_pkg::PH_END: begin
        if (c != crhp_pkg::CH_SLASH) begin
          take_digit(c);
        end else if (number_bad()) begin
          reject(crhp_pkg::ST_OVERFLOW);
        end else if (digit_acc < start_pos) begin
          reject(crhp_pkg::ST_INVALID);
        end else begin
          end_pos = digit_acc;
          clear_number();
          parse_phase = crhp_pkg::PH_TOTAL;
        end
      end
      crhp_pkg::PH_TOTAL: begin
        // A star in place of the total ends parsing without an error.
        if (c == crhp_pkg::CH_STAR && !got_digit && !digits_done) begin
          parse_phase = crhp_pkg::PH_DONE;
        end else begin
          take_digit(c);
        end
      end
      crhp_pkg::PH_STAR_WAIT: begin
        if (c == crhp_pkg::CH_SLASH) begin
          clear_number();
          parse_phase = crhp_pkg::PH_STAR_TOTAL;
        end
      end
      crhp_pkg::PH_STAR_TOTAL: take_digit(c);
      default: ;
    endcase

    if (item.last) begin
      done = 1'b1;
      case (parse_phase)
        crhp_pkg::PH_PREFIX: res.status = crhp_pkg::ST_NOT_BYTES;
        crhp_pkg::PH_FIRST, crhp_pkg::PH_START, crhp_pkg::PH_END: begin
          res.status = crhp_pkg::ST_INVALID;
        end
        crhp_pkg::PH_TOTAL: begin
          if (number_bad()) begin
            res.status = crhp_pkg::ST_OVERFLOW;
          end else begin
            res.range_start  = start_pos;
            res.range_end    = end_pos;
            res.total_length = digit_acc;
            res.total_valid  = 1'b1;
          end
        end
        crhp_pkg::PH_STAR_WAIT: ;
        crhp_pkg::PH_STAR_TOTAL: begin
          if (got_digit && !digits_done && !acc_overflow) begin
            res.total_length = digit_acc;
            res.total_valid  = 1'b1;
          end
        end
        default: begin
          if (error_code != crhp_pkg::ST_OK) begin
            res.status = error_code;
          end else begin
            res.range_start = start_pos;
            res.range_end   = end_pos;
          end
        end
      endcase
      reset_parser();
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic report_field(input string name, input logic [63:0] want_v,
                              input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      error_count++;
    end
  endtask

  task automatic check_result(input crhp_pkg::out_item_t got);
    crhp_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result request with nothing pending: status %0d", got.status);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    status_count[want.status]++;
    report_field("status", 64'(want.status), 64'(got.status));
    report_field("total_valid", 64'(want.total_valid), 64'(got.total_valid));
    report_field("range_start", want.range_start, got.range_start);
    report_field("range_end", want.range_end, got.range_end);
    report_field("total_length", want.total_length, got.total_length);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mode 0 never idles, mode 1 idles uniformly, mode 2 idles now and then.
  function automatic int draw_wait(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, MAX_WAIT);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
    endcase
  endfunction

  function automatic crhp_pkg::out_item_t result_of(input logic [2:0] st, input logic ht,
                                                    input logic [63:0] s,
                                                    input logic [63:0] e,
                                                    input logic [63:0] t);
    crhp_pkg::out_item_t r;
    r.status       = st;
    r.total_valid  = ht;
    r.range_start  = s;
    r.range_end    = e;
    r.total_length = t;
    return r;
  endfunction

  // A result that carries only a status code.
  function automatic crhp_pkg::out_item_t bare_result(input logic [2:0] st);
    return result_of(st, 1'b0, 64'd0, 64'd0, 64'd0);
  endfunction

  task automatic add_row(input string text, input bit fixed,
                         input crhp_pkg::out_item_t want);
    stim_row_t row;
    row.text  = text;
    row.fixed = fixed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  task automatic append_text(input string text);
    for (int i = 0; i < text.len(); i++) header_bytes.push_back(text[i]);
  endtask

  function automatic logic [63:0] rand_number();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NUM_MAX;
      2:       return NUM_MAX - 64'($urandom_range(0, 20));
      default: return ({$urandom, $urandom} >> $urandom_range(0, 63)) & NUM_MAX;
    endcase
  endfunction

  function automatic string junk_text();
    string pool;
    string text;
    int    idx;
    pool = "abcxyzXYZ ;,.#";
    text = "";
    repeat ($urandom_range(1, 3)) begin
      idx  = $urandom_range(0, pool.len() - 1);
      text = {text, pool.substr(idx, idx)};
    end
    return text;
  endfunction

  // Decimal text of a number, sometimes padded, too long, or with a tail.
  function automatic string field_text(input logic [63:0] value);
    string text;
    case ($urandom_range(0, 11))
      0:       text = $sformatf("%0d%0d", NUM_MAX - 64'($urandom_range(0, 999)),
                                $urandom_range(0, 9));
      1:       text = {"00", $sformatf("%0d", value)};
      default: text = $sformatf("%0d", value);
    endcase
    if ($urandom_range(0, 7) == 0) text = {text, junk_text()};
    return text;
  endfunction

  // Mostly well-formed headers with random content, plus broken ones and noise.
  task automatic build_random_header();
    string       text;
    string       tail;
    logic [63:0] lo_pos;
    logic [63:0] hi_pos;
    int          kind;
    header_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      if ($urandom_range(0, 1) == 0) append_text("bytes ");
      repeat ($urandom_range(1, 30)) header_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind >= 55 && kind < 70) begin
      // Star form, with or without a total.
      case ($urandom_range(0, 5))
        0:       tail = "*";
        1:       tail = "";
        2:       tail = field_text(rand_number());
        default: tail = $sformatf("%0d", rand_number());
      endcase
      text = "bytes *";
      if ($urandom_range(0, 4) == 0) text = {text, junk_text()};
      if ($urandom_range(0, 7) != 0) text = {text, "/", tail};
    end else begin
      lo_pos = rand_number();
      case ($urandom_range(0, 5))
        0: hi_pos = lo_pos;
        1: hi_pos = rand_number();
        default: begin
          hi_pos = lo_pos + (rand_number() >> $urandom_range(0, 63));
          if (hi_pos < lo_pos || hi_pos > NUM_MAX) hi_pos = NUM_MAX;
        end
      endcase
      case ($urandom_range(0, 9))
        0:       tail = ($urandom_range(0, 1) == 0) ? "*" : {"*", junk_text()};
        1:       tail = "";
        default: tail = field_text(rand_number());
      endcase
      text = {"bytes ", field_text(lo_pos), "-", field_text(hi_pos), "/", tail};
    end
    append_text(text);
    if (kind >= 70) begin
      // Break the header: cut it short, corrupt a byte, or add a minus sign.
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, header_bytes.size() - 1)) void'(header_bytes.pop_back());
        1: header_bytes[$urandom_range(0, header_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        2: header_bytes[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
        default: header_bytes.insert(6, crhp_pkg::CH_DASH);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offers one request and returns right after the edge that accepts it.
  task automatic send_byte(input crhp_pkg::in_item_t item);
    int wait_cycles;
    bit stalled;
    wait_cycles = draw_wait(in_mode);
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      stalled = (in_stall !== 1'b0);
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_header(input bit fixed, input crhp_pkg::out_item_t fixed_want);
    crhp_pkg::in_item_t  item;
    crhp_pkg::out_item_t predicted;
    bit                  produced;
    if ($urandom_range(0, 3) == 0) in_mode = $urandom_range(0, 2);
    for (int i = 0; i < header_bytes.size(); i++) begin
      item.data_byte = header_bytes[i];
      item.last      = (i == header_bytes.size() - 1);
      send_byte(item);
      bytes_sent++;
      parse_byte(item, produced, predicted);
      if (produced) pending_results.push_back(fixed ? fixed_want : predicted);
    end
    headers_sent++;
  endtask

  // Directed headers: extremes, every status and each special case.
  task automatic build_table();
    crhp_pkg::out_item_t none;
    none = '0;
    add_row("bytes 0-0/1", 1'b1, result_of(crhp_pkg::ST_OK, 1'b1, 64'd0, 64'd0, 64'd1));
    add_row("bytes 0-18446744073709551615/18446744073709551615", 1'b1,
            result_of(crhp_pkg::ST_OK, 1'b1, 64'd0, NUM_MAX, NUM_MAX));
    add_row("bytes 18446744073709551615-18446744073709551615/*", 1'b1,
            result_of(crhp_pkg::ST_OK, 1'b0, NUM_MAX, NUM_MAX, 64'd0));
    add_row("bytes 18446744073709551616-1/2", 1'b1, bare_result(crhp_pkg::ST_OVERFLOW));
    add_row("bytes 0-18446744073709551616/5", 1'b1, bare_result(crhp_pkg::ST_OVERFLOW));
    add_row("bytes 1-2/18446744073709551616", 1'b1, bare_result(crhp_pkg::ST_OVERFLOW));
    add_row("Bytes 0-1/2", 1'b1, bare_result(crhp_pkg::ST_NOT_BYTES));
    add_row("byt", 1'b1, bare_result(crhp_pkg::ST_NOT_BYTES));
    add_row("bytes ", 1'b1, bare_result(crhp_pkg::ST_INVALID));
    add_row("bytes -5-9/10", 1'b1, bare_result(crhp_pkg::ST_NEGATIVE));
    add_row("bytes 100", 1'b1, bare_result(crhp_pkg::ST_INVALID));
    add_row("bytes 1-5", 1'b1, bare_result(crhp_pkg::ST_INVALID));
    add_row("bytes 9-5/10", 1'b1, bare_result(crhp_pkg::ST_INVALID));
    add_row("bytes x-5/10", 1'b1, bare_result(crhp_pkg::ST_OVERFLOW));
    add_row("bytes 5-/10", 1'b1, bare_result(crhp_pkg::ST_OVERFLOW));
    add_row("bytes 0-1/", 1'b1, bare_result(crhp_pkg::ST_OVERFLOW));
    add_row("bytes */100", 1'b1,
            result_of(crhp_pkg::ST_OK, 1'b1, 64'd0, 64'd0, 64'd100));
    add_row("bytes */*", 1'b1, bare_result(crhp_pkg::ST_OK));
    add_row("bytes *", 1'b1, bare_result(crhp_pkg::ST_OK));
    add_row("bytes */12a", 1'b1, bare_result(crhp_pkg::ST_OK));
    add_row("bytes */18446744073709551616", 1'b1, bare_result(crhp_pkg::ST_OK));
    add_row("bytes 12ab-34cd/56ef", 1'b0, none);
    add_row("bytes 007-7/3*x", 1'b0, none);
    add_row("bytes 7-7/*junk", 1'b0, none);
    add_row("bytes*/5", 1'b0, none);
  endtask

  initial begin : stimulus
    int random_start;
    int directed_headers;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    reset_parser();
    build_table();
    foreach (stim_table[r]) begin
      header_bytes.delete();
      append_text(stim_table[r].text);
      send_header(stim_table[r].fixed, stim_table[r].want);
    end
    directed_headers = headers_sent;
    random_start     = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      build_random_header();
      send_header(1'b0, '0);
    end
    in_valid <= 1'b0;

    // Let the last results come out, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d headers (%0d directed) as %0d bytes; %0d results checked.",
             headers_sent, directed_headers, bytes_sent, results_checked);
    $display("Status mix: %0d ok, %0d not bytes, %0d negative, %0d invalid, %0d overflow.",
             status_count[crhp_pkg::ST_OK], status_count[crhp_pkg::ST_NOT_BYTES],
             status_count[crhp_pkg::ST_NEGATIVE], status_count[crhp_pkg::ST_INVALID],
             status_count[crhp_pkg::ST_OVERFLOW]);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Stalls a random number of cycles before each result request, with one
  // long hold so that the block backs up into its input.
  initial begin : result_sink
    int wait_cycles;
    bit took;
    forever begin
      if ($urandom_range(0, 7) == 0) out_mode = $urandom_range(0, 2);
      wait_cycles = (results_checked == LONG_HOLD_AT) ? LONG_HOLD : draw_wait(out_mode);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = (out_valid === 1'b1);
        if (took) check_result(out_data);
        @(posedge clk);
      end while (!took);
    end
  end

endmodule
